### rtl/ffpa_pkg.sv
// Shared constants for the first-fit pool allocator: field widths, stream
// widths, status codes and default sizes. Depends on nothing.
package ffpa_pkg;

    localparam int POOL_BYTES_DEF = 4096;
    localparam int HEADER_BYTES   = 16;

    localparam int FIELD_W     = 13;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 16;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

endpackage

### rtl/first_fit_pool_allocator_top.sv
// First-fit pool allocator with an address-ordered, coalescing free list; one request in work.
// An allocate walks to the first entry that fits, else falls to the bump pointer; a free
// walks to its place in address order, merges with its neighbours and, when it does not
// join its predecessor, points that link or the head at it; a null or out-of-range free
// goes straight to the result. The walk reads one entry per cycle from the header memories.
// Reset (aresetn, synchronous, active low) empties the list, zeroes the bump pointer and idles.
module first_fit_pool_allocator_top #(
    parameter int POOL_BYTES = ffpa_pkg::POOL_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Request channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: request_size [12:0], payload_address [25:13], zero fill.
    input  logic [ffpa_pkg::S_TDATA_W-1:0]      s_tdata,
    // Fields from bit 0: action (0 allocate, 1 free).
    input  logic [ffpa_pkg::S_TUSER_W-1:0]      s_tuser,
    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: granted_address [12:0], zero fill.
    output logic [ffpa_pkg::M_TDATA_W-1:0]      m_tdata,
    // Fields from bit 0: status [1:0].
    output logic [ffpa_pkg::STATUS_W-1:0]       m_tuser
);

    // Index width of the header memories, and a width that can also hold the
    // null link, which is encoded as POOL_BYTES itself.
    localparam int IW = $clog2(POOL_BYTES);
    localparam int AW = $clog2(POOL_BYTES + 1);
    localparam int FW = ffpa_pkg::FIELD_W;
    // Working width for sums of an address, a size and a header.
    localparam int SW = ((AW > FW) ? AW : FW) + 2;

    localparam logic [AW-1:0] NULL_LINK = AW'(POOL_BYTES);
    localparam logic [SW-1:0] POOL_S    = SW'(POOL_BYTES);
    localparam logic [SW-1:0] HDR_S     = SW'(ffpa_pkg::HEADER_BYTES);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_AWALK  = 4'd1;
    localparam logic [3:0] ST_BUMP   = 4'd2;
    localparam logic [3:0] ST_FWALK  = 4'd3;
    localparam logic [3:0] ST_FRDB   = 4'd4;
    localparam logic [3:0] ST_FRDC   = 4'd5;
    localparam logic [3:0] ST_FMERGE = 4'd6;
    localparam logic [3:0] ST_FLINKP = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    function automatic logic is_null(input logic [AW-1:0] h);
        return h >= NULL_LINK;
    endfunction

    function automatic logic [AW-1:0] norm_link(input logic [AW-1:0] h);
        return is_null(h) ? NULL_LINK : h;
    endfunction

    // Size of two blocks joined with the header between them, saturated at the pool size.
    function automatic logic [AW-1:0] merged(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + HDR_S + SW'(b);
        return (s > POOL_S) ? NULL_LINK : s[AW-1:0];
    endfunction

    // Header memories: size and link of the block whose header sits at the index. They are
    // not cleared, as entries are only read after they were written.
    logic [AW-1:0] size_mem [POOL_BYTES];
    logic [AW-1:0] link_mem [POOL_BYTES];
    logic [AW-1:0] size_q;
    logic [AW-1:0] link_q;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          size_we;
    logic          link_we;
    logic [AW-1:0] size_wd;
    logic [AW-1:0] link_wd;

    // Control registers.
    logic [3:0]    state_reg,     state_next;
    logic [AW-1:0] bump_reg,      bump_next;
    logic [AW-1:0] head_reg,      head_next;
    logic [AW-1:0] n_reg,         n_next;
    logic          m_valid_reg,   m_valid_next;

    // Working registers of the request in hand.
    logic [AW-1:0] prev_reg,      prev_next;
    logic [AW-1:0] prev_size_reg, prev_size_next;
    logic [AW-1:0] curr_reg,      curr_next;
    logic [AW-1:0] block_reg,     block_next;
    logic [AW-1:0] blk_size_reg,  blk_size_next;
    logic [FW-1:0] req_reg,       req_next;
    logic [ffpa_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [FW-1:0] res_addr_reg,  res_addr_next;
    logic [ffpa_pkg::STATUS_W-1:0] m_user_reg,     m_user_next;
    logic [FW-1:0] m_data_reg,    m_data_next;

    // Request fields.
    logic          s_fire;
    logic          in_action;
    logic [FW-1:0] in_size;
    logic [FW-1:0] in_addr;

    // Datapath terms.
    logic [SW-1:0] addr_s;
    logic [SW-1:0] blk_s;
    logic          free_bad;
    logic [AW-1:0] next_link;
    logic          more_steps;
    logic [SW-1:0] grant_sum;
    logic [SW-1:0] bump_grant;
    logic [SW-1:0] bump_sum;
    logic          fits;
    logic [SW-1:0] left_end;
    logic          join_left;
    logic [AW-1:0] new_blk;
    logic [AW-1:0] new_size;
    logic [SW-1:0] right_end;
    logic          join_right;
    logic [AW-1:0] final_size;

    assign in_action = s_tuser[0];
    assign in_size   = s_tdata[FW-1:0];
    assign in_addr   = s_tdata[2*FW-1:FW];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = {{(ffpa_pkg::M_TDATA_W - FW){1'b0}}, m_data_reg};

    // Validity of a free and the header offset it names.
    assign addr_s   = SW'(in_addr);
    assign blk_s    = addr_s - HDR_S;
    assign free_bad = (addr_s < HDR_S) || (blk_s >= POOL_S);

    // One step along the list: the entry just read is curr_reg.
    assign next_link  = norm_link(link_q);
    assign more_steps = !is_null(next_link) && ((SW'(n_reg) + SW'(1)) < POOL_S);
    assign fits       = SW'(size_q) >= SW'(req_reg);
    assign grant_sum  = SW'(curr_reg) + HDR_S;
    assign bump_grant = SW'(bump_reg) + HDR_S;
    assign bump_sum   = bump_grant + SW'(req_reg);

    // Coalescing decision. The size of curr_reg and its link arrive from the
    // memories in the merge state; the walk leaves the size of prev_reg behind.
    assign left_end   = SW'(prev_reg) + HDR_S + SW'(prev_size_reg);
    assign join_left  = !is_null(prev_reg) && (left_end == SW'(block_reg));
    assign new_blk    = join_left ? prev_reg : block_reg;
    assign new_size   = join_left ? merged(prev_size_reg, blk_size_reg) : blk_size_reg;
    assign right_end  = SW'(new_blk) + HDR_S + SW'(new_size);
    assign join_right = !is_null(curr_reg) && (right_end == SW'(curr_reg));
    assign final_size = join_right ? merged(new_size, size_q) : new_size;

    always_comb begin
        state_next      = state_reg;
        bump_next       = bump_reg;
        head_next       = head_reg;
        n_next          = n_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        prev_next       = prev_reg;
        prev_size_next  = prev_size_reg;
        curr_next       = curr_reg;
        block_next      = block_reg;
        blk_size_next   = blk_size_reg;
        req_next        = req_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_user_next     = m_user_reg;
        m_data_next     = m_data_reg;
        rd_addr         = curr_reg;
        wr_addr         = prev_reg;
        size_we         = 1'b0;
        link_we         = 1'b0;
        size_wd         = final_size;
        link_wd         = next_link;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    prev_next = NULL_LINK;
                    curr_next = head_reg;
                    n_next    = '0;
                    req_next  = in_size;
                    rd_addr   = head_reg;
                    if (in_action == ffpa_pkg::ACTION_ALLOC) begin
                        state_next = is_null(head_reg) ? ST_BUMP : ST_AWALK;
                    end else if (free_bad) begin
                        res_status_next = ffpa_pkg::STATUS_IGNORED;
                        res_addr_next   = '0;
                        state_next      = ST_OUT;
                    end else begin
                        block_next = blk_s[AW-1:0];
                        if (!is_null(head_reg) && (SW'(head_reg) < blk_s)) begin
                            state_next = ST_FWALK;
                        end else begin
                            state_next = ST_FRDB;
                        end
                    end
                end
            end
            ST_AWALK: begin
                if (fits) begin
                    // Unlink the whole block.
                    if (is_null(prev_reg)) begin
                        head_next = next_link;
                    end else begin
                        link_we = 1'b1;
                    end
                    res_status_next = ffpa_pkg::STATUS_DONE;
                    res_addr_next   = grant_sum[FW-1:0];
                    state_next      = ST_OUT;
                end else begin
                    prev_next      = curr_reg;
                    prev_size_next = size_q;
                    curr_next      = next_link;
                    n_next         = n_reg + AW'(1);
                    rd_addr        = next_link;
                    state_next     = more_steps ? ST_AWALK : ST_BUMP;
                end
            end
            ST_BUMP: begin
                if (bump_sum > POOL_S) begin
                    res_status_next = ffpa_pkg::STATUS_OOM;
                    res_addr_next   = '0;
                end else begin
                    wr_addr         = bump_reg;
                    size_we         = 1'b1;
                    size_wd         = AW'(req_reg);
                    link_we         = 1'b1;
                    link_wd         = NULL_LINK;
                    bump_next       = bump_sum[AW-1:0];
                    res_status_next = ffpa_pkg::STATUS_DONE;
                    res_addr_next   = bump_grant[FW-1:0];
                end
                state_next = ST_OUT;
            end
            ST_FWALK: begin
                prev_next      = curr_reg;
                prev_size_next = size_q;
                curr_next      = next_link;
                n_next         = n_reg + AW'(1);
                rd_addr        = next_link;
                if (more_steps && (next_link < block_reg)) begin
                    state_next = ST_FWALK;
                end else begin
                    state_next = ST_FRDB;
                end
            end
            ST_FRDB: begin
                rd_addr    = block_reg;
                state_next = ST_FRDC;
            end
            ST_FRDC: begin
                blk_size_next = size_q;
                rd_addr       = curr_reg;
                state_next    = ST_FMERGE;
            end
            ST_FMERGE: begin
                // Every change to the surviving block's header goes in one write.
                wr_addr = new_blk;
                size_we = join_left || join_right;
                size_wd = final_size;
                link_we = join_right || !join_left;
                link_wd = join_right ? next_link : curr_reg;
                res_status_next = ffpa_pkg::STATUS_DONE;
                res_addr_next   = '0;
                state_next      = ST_OUT;
                if (!join_left) begin
                    if (is_null(prev_reg)) begin
                        head_next = block_reg;
                    end else begin
                        state_next = ST_FLINKP;
                    end
                end
            end
            ST_FLINKP: begin
                // The predecessor now points at the freed block.
                wr_addr    = prev_reg;
                link_we    = 1'b1;
                link_wd    = block_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = res_addr_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bump_reg    <= '0;
            head_reg    <= NULL_LINK;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bump_reg    <= bump_next;
            head_reg    <= head_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg       <= prev_next;
        prev_size_reg  <= prev_size_next;
        curr_reg       <= curr_next;
        block_reg      <= block_next;
        blk_size_reg   <= blk_size_next;
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_user_reg     <= m_user_next;
        m_data_reg     <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[wr_addr[IW-1:0]] <= size_wd;
        end
        size_q <= size_mem[rd_addr[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[wr_addr[IW-1:0]] <= link_wd;
        end
        link_q <= link_mem[rd_addr[IW-1:0]];
    end

    // The bump pointer never passes the end of the pool.
    a_bump_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        bump_reg <= NULL_LINK)
        else $error("bump pointer beyond pool");

    // The list head is a header inside the pool or the null link.
    a_head_encoded: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= NULL_LINK)
        else $error("free list head badly encoded");

    // Failed or ignored requests never hand out an address.
    a_no_grant_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_user_reg != ffpa_pkg::STATUS_DONE)) |-> (m_data_reg == '0))
        else $error("address granted with a failure status");

    // Header writes only happen while a request is in work, never when a new one is taken.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (size_we || link_we) |-> (state_reg != ST_IDLE) && (state_reg != ST_OUT))
        else $error("header write outside a request");

    // A walk step never runs past the bound of one pass over the pool.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_AWALK) || (state_reg == ST_FWALK)) |-> (SW'(n_reg) < POOL_S))
        else $error("list walk beyond its bound");

endmodule
